// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same clock edge.
`define CHK_IMPLY(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qrs_pkg.sv =====
// Shared types, widths and helpers for the quadratic root solver.
// Depends on nothing.
package qrs_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_WIDTH  = 34;

  localparam int PROD_W  = 2 * COEF_WIDTH;
  localparam int DISC_W  = PROD_W + 3;
  localparam int MAG_W   = PROD_W + 1;
  localparam int ROOT_W  = (MAG_W + 2 * FRAC_BITS + 1) / 2;
  localparam int X_W     = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int NB_W    = COEF_WIDTH + FRAC_BITS + 1;
  localparam int DEN_W   = COEF_WIDTH + 1;
  localparam int QUO_W   = ROOT_W + 1;
  localparam int SQ_W    = QUO_W + 1;
  localparam int DREM_W  = DEN_W;

  localparam int SQRT_CELLS = ROOT_W;
  localparam int DIV_CELLS  = QUO_W;
  localparam int LATENCY    = SQRT_CELLS + DIV_CELLS + 5;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_TWO     = 2'd1,
    KIND_DOUBLE  = 2'd2,
    KIND_COMPLEX = 2'd3
  } kind_t;

  typedef struct packed {
    logic                     valid;
    kind_t                    kind;
    logic signed [NB_W-1:0]   nb;
    logic                     den_neg;
    logic [DEN_W-1:0]         den_mag;
    logic                     sgn1;
    logic                     sgn2;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [X_W-1:0]    x;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem1;
    logic [DREM_W-1:0] rem2;
    logic [QUO_W-1:0]  num1;
    logic [QUO_W-1:0]  num2;
  } div_t;

  function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [SQ_W-1:0] v);
    logic signed [SQ_W-1:0] hi;
    logic signed [SQ_W-1:0] lo;
    hi = (SQ_W'(1) <<< (OUT_WIDTH - 1)) - SQ_W'(1);
    lo = -hi - SQ_W'(1);
    if (v > hi) begin
      return hi[OUT_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[OUT_WIDTH-1:0];
    end
    return v[OUT_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/qrs_sqrt_cell.sv =====
// One root digit of the scaled square root, one pipeline stage.
// Depends on qrs_pkg.
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  side_t side_i,
  input  sqrt_t sq_i,
  output side_t side_o,
  output sqrt_t sq_o
);

  side_t            side_r;
  sqrt_t            sq_r;
  sqrt_t            sq_nxt;
  logic [REM_W+1:0] part;
  logic [REM_W+1:0] trial;

  always_comb begin
    part  = {sq_i.rem, sq_i.x[X_W-1 -: 2]};
    trial = (REM_W+2)'({sq_i.root, 2'b01});
    sq_nxt.x = {sq_i.x[X_W-3:0], 2'b00};
    if (part >= trial) begin
      sq_nxt.rem  = REM_W'(part - trial);
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = part[REM_W-1:0];
      sq_nxt.root = {sq_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r <= side_i;
    end
    sq_r <= sq_nxt;
  end

  assign side_o = side_r;
  assign sq_o   = sq_r;

endmodule

// ===== rtl/qrs_div_cell.sv =====
// One quotient bit for both division lanes, one pipeline stage.
// Depends on qrs_pkg.
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  side_t side_i,
  input  div_t  dv_i,
  output side_t side_o,
  output div_t  dv_o
);

  side_t             side_r;
  div_t              dv_r;
  div_t              dv_nxt;
  logic [DREM_W:0]   p1;
  logic [DREM_W:0]   p2;
  logic [DREM_W:0]   dd;

  always_comb begin
    dd = (DREM_W+1)'(side_i.den_mag);
    p1 = {dv_i.rem1, dv_i.num1[QUO_W-1]};
    p2 = {dv_i.rem2, dv_i.num2[QUO_W-1]};
    if (p1 >= dd) begin
      dv_nxt.rem1 = DREM_W'(p1 - dd);
      dv_nxt.num1 = {dv_i.num1[QUO_W-2:0], 1'b1};
    end else begin
      dv_nxt.rem1 = p1[DREM_W-1:0];
      dv_nxt.num1 = {dv_i.num1[QUO_W-2:0], 1'b0};
    end
    if (p2 >= dd) begin
      dv_nxt.rem2 = DREM_W'(p2 - dd);
      dv_nxt.num2 = {dv_i.num2[QUO_W-2:0], 1'b1};
    end else begin
      dv_nxt.rem2 = p2[DREM_W-1:0];
      dv_nxt.num2 = {dv_i.num2[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else begin
      side_r <= side_i;
    end
    dv_r <= dv_nxt;
  end

  assign side_o = side_r;
  assign dv_o   = dv_r;

endmodule

// ===== rtl/quadratic_root_solver_core.sv =====
// Throughput: one transaction per cycle; busy stays low and start is never held off.
// The pipeline holds the 33 square-root cells and the 34 divider cells.
// Reset: synchronous, active low; clears every valid flag, drops work in flight.
// Top level of the quadratic root solver; depends on qrs_pkg, qrs_sqrt_cell,
// qrs_div_cell.
module quadratic_root_solver_core
  import qrs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COEF_WIDTH-1:0] in_coeff_a,
  input  logic signed [COEF_WIDTH-1:0] in_coeff_b,
  input  logic signed [COEF_WIDTH-1:0] in_coeff_c,
  output logic                        out_valid,
  output logic [1:0]                  out_root_kind,
  output logic signed [OUT_WIDTH-1:0] out_first_value,
  output logic signed [OUT_WIDTH-1:0] out_second_value
);

  // stage A: products
  logic                         va_r;
  logic signed [PROD_W-1:0]     bb_r;
  logic signed [PROD_W-1:0]     ac_r;
  logic signed [COEF_WIDTH-1:0] a_r;
  logic signed [COEF_WIDTH-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start;
    end
    bb_r <= in_coeff_b * in_coeff_b;
    ac_r <= in_coeff_a * in_coeff_c;
    a_r  <= in_coeff_a;
    b_r  <= in_coeff_b;
  end

  // stage B: discriminant and classification
  logic signed [DISC_W-1:0] disc;
  logic [DISC_W-1:0]        disc_mag;
  logic signed [DEN_W-1:0]  den;
  side_t                    side_b_nxt;
  sqrt_t                    sq_b_nxt;
  side_t                    side_b_r;
  sqrt_t                    sq_b_r;

  always_comb begin
    disc = DISC_W'(bb_r) - (DISC_W'(ac_r) <<< 2);
    disc_mag = disc[DISC_W-1] ? DISC_W'(-disc) : DISC_W'(disc);
    den = DEN_W'(a_r) <<< 1;
    side_b_nxt.valid   = va_r;
    side_b_nxt.nb      = -(NB_W'(b_r) <<< FRAC_BITS);
    side_b_nxt.den_neg = den[DEN_W-1];
    side_b_nxt.den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    side_b_nxt.sgn1    = 1'b0;
    side_b_nxt.sgn2    = 1'b0;
    if (a_r == '0) begin
      side_b_nxt.kind = KIND_NONE;
    end else if (disc[DISC_W-1]) begin
      side_b_nxt.kind = KIND_COMPLEX;
    end else if (disc == '0) begin
      side_b_nxt.kind = KIND_DOUBLE;
    end else begin
      side_b_nxt.kind = KIND_TWO;
    end
    sq_b_nxt.rem  = '0;
    sq_b_nxt.root = '0;
    sq_b_nxt.x    = X_W'({disc_mag[MAG_W-1:0], {(2*FRAC_BITS){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_b_r.valid <= 1'b0;
    end else begin
      side_b_r <= side_b_nxt;
    end
    sq_b_r <= sq_b_nxt;
  end

  // square-root chain
  side_t sq_side [SQRT_CELLS+1];
  sqrt_t sq_data [SQRT_CELLS+1];

  assign sq_side[0] = side_b_r;
  assign sq_data[0] = sq_b_r;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (sq_side[i]),
      .sq_i   (sq_data[i]),
      .side_o (sq_side[i+1]),
      .sq_o   (sq_data[i+1])
    );
  end

  // combine stage: numerators, signs and magnitudes
  side_t                   sc;
  logic signed [SQ_W-1:0]  s_val;
  logic signed [SQ_W-1:0]  n1;
  logic signed [SQ_W-1:0]  n2;
  side_t                   side_c_nxt;
  div_t                    dv_c_nxt;
  side_t                   side_c_r;
  div_t                    dv_c_r;

  always_comb begin
    sc    = sq_side[SQRT_CELLS];
    s_val = SQ_W'(sq_data[SQRT_CELLS].root);
    n1    = SQ_W'(sc.nb);
    n2    = SQ_W'(sc.nb);
    unique case (sc.kind)
      KIND_TWO: begin
        n1 = SQ_W'(sc.nb) + s_val;
        n2 = SQ_W'(sc.nb) - s_val;
      end
      KIND_COMPLEX: begin
        n2 = s_val;
      end
      default: begin
        n2 = SQ_W'(sc.nb);
      end
    endcase
    side_c_nxt      = sc;
    side_c_nxt.sgn1 = n1[SQ_W-1] ^ sc.den_neg;
    side_c_nxt.sgn2 = (sc.kind == KIND_COMPLEX) ? 1'b0 : (n2[SQ_W-1] ^ sc.den_neg);
    dv_c_nxt.rem1 = '0;
    dv_c_nxt.rem2 = '0;
    dv_c_nxt.num1 = n1[SQ_W-1] ? QUO_W'(-n1) : QUO_W'(n1);
    dv_c_nxt.num2 = n2[SQ_W-1] ? QUO_W'(-n2) : QUO_W'(n2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_c_r.valid <= 1'b0;
    end else begin
      side_c_r <= side_c_nxt;
    end
    dv_c_r <= dv_c_nxt;
  end

  // divider chain
  side_t dv_side [DIV_CELLS+1];
  div_t  dv_data [DIV_CELLS+1];

  assign dv_side[0] = side_c_r;
  assign dv_data[0] = dv_c_r;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    qrs_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (dv_side[j]),
      .dv_i   (dv_data[j]),
      .side_o (dv_side[j+1]),
      .dv_o   (dv_data[j+1])
    );
  end

  // sign stage
  side_t                  sd;
  logic signed [SQ_W-1:0] q1;
  logic signed [SQ_W-1:0] q2;
  logic                   vs_r;
  kind_t                  ks_r;
  logic signed [SQ_W-1:0] r1_r;
  logic signed [SQ_W-1:0] r2_r;

  always_comb begin
    sd = dv_side[DIV_CELLS];
    q1 = SQ_W'(dv_data[DIV_CELLS].num1);
    q2 = SQ_W'(dv_data[DIV_CELLS].num2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= sd.valid;
    end
    ks_r <= sd.kind;
    r1_r <= sd.sgn1 ? -q1 : q1;
    r2_r <= sd.sgn2 ? -q2 : q2;
  end

  // output stage: order, saturate, drop values when not quadratic
  logic                        out_valid_r;
  logic [1:0]                  kind_r;
  logic signed [OUT_WIDTH-1:0] first_r;
  logic signed [OUT_WIDTH-1:0] second_r;
  logic signed [OUT_WIDTH-1:0] first_nxt;
  logic signed [OUT_WIDTH-1:0] second_nxt;

  always_comb begin
    first_nxt  = sat_out(r1_r);
    second_nxt = sat_out(r2_r);
    if (ks_r == KIND_NONE) begin
      first_nxt  = '0;
      second_nxt = '0;
    end else if (ks_r == KIND_TWO && r1_r < r2_r) begin
      first_nxt  = sat_out(r2_r);
      second_nxt = sat_out(r1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vs_r;
    end
    kind_r   <= ks_r;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  assign busy             = 1'b0;
  assign out_valid        = out_valid_r;
  assign out_root_kind    = kind_r;
  assign out_first_value  = first_r;
  assign out_second_value = second_r;

endmodule

// ===== rtl/qrs_checker.sv =====
// Port-level checker for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qrs_checker
  import qrs_pkg::*;
(
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_root_kind,
  input logic signed [OUT_WIDTH-1:0] out_first_value,
  input logic signed [OUT_WIDTH-1:0] out_second_value
);

  `CHK_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
  `CHK_IMPLY(a_result_has_cause, clk, rst_n, out_valid, $past(start, LATENCY), "result without transaction")
  `CHK_IMPLY(a_none_zero, clk, rst_n, out_valid && out_root_kind == KIND_NONE, out_first_value == '0 && out_second_value == '0, "values not cleared")
  `CHK_IMPLY(a_two_ordered, clk, rst_n, out_valid && out_root_kind == KIND_TWO, out_first_value >= out_second_value, "roots out of order")
  `CHK_IMPLY(a_imag_nonneg, clk, rst_n, out_valid && out_root_kind == KIND_COMPLEX, !out_second_value[OUT_WIDTH-1], "negative imaginary part")

endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_root_kind    (out_root_kind),
  .out_first_value  (out_first_value),
  .out_second_value (out_second_value)
);
